// File: rtl/sse_pkg.sv
// Shared types and codes for the sorted set engine.
package sse_pkg;

    localparam int KEY_W = 32;

    // Request kinds.
    localparam logic [2:0] REQ_INSERT = 3'd0;
    localparam logic [2:0] REQ_REMOVE = 3'd1;
    localparam logic [2:0] REQ_SEARCH = 3'd2;
    localparam logic [2:0] REQ_PRED   = 3'd3;
    localparam logic [2:0] REQ_SUCC   = 3'd4;

    // Result status codes.
    localparam logic [1:0] ST_DONE   = 2'd0;
    localparam logic [1:0] ST_ABSENT = 2'd1;
    localparam logic [1:0] ST_DUP    = 2'd2;
    localparam logic [1:0] ST_FULL   = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_COMMIT
    } t_state;

    // Request broadcast from the controller to every cell.
    typedef struct packed {
        logic [2:0]              kind;
        logic signed [KEY_W-1:0] key;
        logic                    ins;
        logic                    rem;
    } t_cmd;

    // Partial result that travels from cell to cell during a scan.
    typedef struct packed {
        logic                    found;
        logic                    have;
        logic signed [KEY_W-1:0] nb;
    } t_rec;

    localparam t_rec REC_EMPTY = '{found: 1'b0, have: 1'b0, nb: '0};

endpackage

// File: rtl/sse_cell.sv
// One slot of the sorted array: key storage, compare, shift and result merge.
module sse_cell #(
    parameter int IDX   = 0,
    parameter int CNT_W = 5
) (
    input  logic                             i_clk,
    input  sse_pkg::t_cmd                    i_cmd,
    input  logic [CNT_W-1:0]                 i_count,
    input  logic                             i_prev_below,
    input  logic signed [sse_pkg::KEY_W-1:0] i_prev_key,
    input  logic signed [sse_pkg::KEY_W-1:0] i_next_key,
    input  sse_pkg::t_rec                    i_rec,
    output logic                             o_below,
    output logic signed [sse_pkg::KEY_W-1:0] o_key,
    output sse_pkg::t_rec                    o_rec
);

    logic signed [sse_pkg::KEY_W-1:0] r_key;
    logic signed [sse_pkg::KEY_W-1:0] n_key;
    sse_pkg::t_rec                    r_rec;
    sse_pkg::t_rec                    n_rec;
    logic                             occupied;
    logic                             lt;
    logic                             eq;
    logic                             gt;

    assign occupied = CNT_W'(IDX) < i_count;
    assign lt       = r_key < i_cmd.key;
    assign eq       = r_key == i_cmd.key;
    assign gt       = !lt && !eq;
    assign o_below  = occupied && lt;
    assign o_key    = r_key;
    assign o_rec    = r_rec;

    always_comb begin
        n_rec       = i_rec;
        n_rec.found = i_rec.found || (occupied && eq);
        // Keys ascend, so the last smaller key is the predecessor and the
        // first larger key is the successor.
        if (i_cmd.kind == sse_pkg::REQ_PRED && occupied && lt) begin
            n_rec.have = 1'b1;
            n_rec.nb   = r_key;
        end else if (i_cmd.kind == sse_pkg::REQ_SUCC && occupied && gt && !i_rec.have) begin
            n_rec.have = 1'b1;
            n_rec.nb   = r_key;
        end
    end

    always_comb begin
        n_key = r_key;
        if (i_cmd.ins && !o_below) begin
            n_key = i_prev_below ? i_cmd.key : i_prev_key;
        end else if (i_cmd.rem && !o_below) begin
            n_key = i_next_key;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
        r_rec <= n_rec;
    end

endmodule

// File: rtl/sse_ctrl.sv
// Request sequencer: accepts items, times the scan, commits and holds results.
module sse_ctrl #(
    parameter int CAPACITY = 16,
    parameter int CNT_W    = 5,
    parameter int IDX_W    = 4
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [2:0]                       i_req_type,
    input  logic signed [sse_pkg::KEY_W-1:0] i_key,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [1:0]                       o_status,
    output logic signed [sse_pkg::KEY_W-1:0] o_neighbour,
    output logic [CNT_W-1:0]                 o_count,
    input  sse_pkg::t_rec                    i_rec,
    output sse_pkg::t_cmd                    o_cmd
);

    sse_pkg::t_state                  r_state;
    sse_pkg::t_state                  n_state;
    logic [IDX_W-1:0]                 r_cnt;
    logic [IDX_W-1:0]                 n_cnt;
    logic [CNT_W-1:0]                 r_count;
    logic [CNT_W-1:0]                 n_count;
    logic [2:0]                       r_kind;
    logic signed [sse_pkg::KEY_W-1:0] r_key;
    logic                             r_out_valid;
    logic                             n_out_valid;
    logic [1:0]                       r_status;
    logic [1:0]                       n_status;
    logic signed [sse_pkg::KEY_W-1:0] r_nb;
    logic signed [sse_pkg::KEY_W-1:0] n_nb;
    logic                             accept;
    logic                             commit;

    assign accept      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_neighbour = r_nb;
    assign o_count     = r_count;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_count     = r_count;
        n_status    = r_status;
        n_nb        = r_nb;
        n_out_valid = r_out_valid && !i_out_ready;
        o_in_ready  = 1'b0;
        commit      = 1'b0;
        o_cmd.kind  = r_kind;
        o_cmd.key   = r_key;
        o_cmd.ins   = 1'b0;
        o_cmd.rem   = 1'b0;
        case (r_state)
            sse_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_cnt   = '0;
                    n_state = sse_pkg::S_SCAN;
                end
            end
            sse_pkg::S_SCAN: begin
                n_cnt = r_cnt + 1'b1;
                // The record passes one cell register at a time; the scan ends once it has passed the last cell.
                if (r_cnt == IDX_W'(CAPACITY - 1)) begin
                    n_state = sse_pkg::S_COMMIT;
                end
            end
            sse_pkg::S_COMMIT: begin
                if (!r_out_valid || i_out_ready) begin
                    commit      = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = sse_pkg::S_IDLE;
                    n_status    = sse_pkg::ST_ABSENT;
                    n_nb        = '0;
                    case (r_kind)
                        sse_pkg::REQ_INSERT: begin
                            if (i_rec.found) begin
                                n_status = sse_pkg::ST_DUP;
                            end else if (r_count >= CNT_W'(CAPACITY)) begin
                                n_status = sse_pkg::ST_FULL;
                            end else begin
                                n_status  = sse_pkg::ST_DONE;
                                o_cmd.ins = 1'b1;
                                n_count   = r_count + 1'b1;
                            end
                        end
                        sse_pkg::REQ_REMOVE: begin
                            if (i_rec.found) begin
                                n_status  = sse_pkg::ST_DONE;
                                o_cmd.rem = 1'b1;
                                n_count   = r_count - 1'b1;
                            end
                        end
                        sse_pkg::REQ_SEARCH: begin
                            if (i_rec.found) begin
                                n_status = sse_pkg::ST_DONE;
                            end
                        end
                        sse_pkg::REQ_PRED, sse_pkg::REQ_SUCC: begin
                            if (i_rec.have) begin
                                n_status = sse_pkg::ST_DONE;
                                n_nb     = i_rec.nb;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            default: begin
                n_state = sse_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sse_pkg::S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt <= n_cnt;
        if (accept) begin
            r_kind <= i_req_type;
            r_key  <= i_key;
        end
        if (commit) begin
            r_status <= n_status;
            r_nb     <= n_nb;
        end
    end

endmodule

// File: rtl/sorted_set_engine_core.sv
// Top level of the sorted set engine: controller plus a row of key cells.
//
// Keeps up to CAPACITY distinct signed 32-bit keys in ascending order, one
// key per cell. The input channel (i_in_valid / o_in_ready) carries a request
// kind and a key; the output channel (o_out_valid / i_out_ready) returns a
// status, a neighbour key and the occupancy after the request.
// Every cell compares its key with the request key at once. A result record
// then moves from cell 0 to the last cell, one cell per cycle, picking up
// the match and the neighbour key, and is followed by a commit step in which
// the cells at and above the insertion or removal point shift together for an
// insert or remove. The next item is taken in the cycle after the commit, so
// the engine never takes a new item before the last one has been committed.
// The result sits in an output register; a new item is accepted and scanned
// while it waits, and only the commit of that item holds until the receiver
// takes the earlier result.
// Reset empties the set and clears the output valid flag; key storage is not
// cleared, since only occupied cells are ever read.
module sorted_set_engine_core #(
    parameter int CAPACITY = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [2:0]                       i_req_type,
    input  logic signed [sse_pkg::KEY_W-1:0] i_key,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [1:0]                       o_status,
    output logic signed [sse_pkg::KEY_W-1:0] o_neighbour,
    output logic [4:0]                       o_occupancy
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);

    sse_pkg::t_cmd                    cmd;
    logic [CNT_W-1:0]                 count;
    logic                             below [CAPACITY];
    logic signed [sse_pkg::KEY_W-1:0] keys  [CAPACITY];
    sse_pkg::t_rec                    recs  [CAPACITY];

    assign o_occupancy = 5'(count);

    sse_ctrl #(
        .CAPACITY (CAPACITY),
        .CNT_W    (CNT_W),
        .IDX_W    (IDX_W)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_req_type  (i_req_type),
        .i_key       (i_key),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_status    (o_status),
        .o_neighbour (o_neighbour),
        .o_count     (count),
        .i_rec       (recs[CAPACITY-1]),
        .o_cmd       (cmd)
    );

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic                             prev_below;
        logic signed [sse_pkg::KEY_W-1:0] prev_key;
        logic signed [sse_pkg::KEY_W-1:0] next_key;
        sse_pkg::t_rec                    rec_in;

        // Cell 0 has nothing below it; the last cell keeps its own key on a remove.
        if (g == 0) begin : g_first
            assign prev_below = 1'b1;
            assign prev_key   = keys[0];
            assign rec_in     = sse_pkg::REC_EMPTY;
        end else begin : g_mid
            assign prev_below = below[g-1];
            assign prev_key   = keys[g-1];
            assign rec_in     = recs[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign next_key = keys[g];
        end else begin : g_inner
            assign next_key = keys[g+1];
        end

        sse_cell #(
            .IDX   (g),
            .CNT_W (CNT_W)
        ) u_cell (
            .i_clk        (i_clk),
            .i_cmd        (cmd),
            .i_count      (count),
            .i_prev_below (prev_below),
            .i_prev_key   (prev_key),
            .i_next_key   (next_key),
            .i_rec        (rec_in),
            .o_below      (below[g]),
            .o_key        (keys[g]),
            .o_rec        (recs[g])
        );
    end

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for the sorted set engine: directed table, then weighted random items.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SET_CAP    = 16;
    localparam int RUN_LIMIT  = 200000;
    localparam int HOLD_LEN   = 400;
    localparam int N_RANDOM   = 1100;
    localparam int SETTLE     = 3 * (SET_CAP + 2);

    // Request kinds that the block does not define.
    localparam logic [2:0] REQ_RSVD5 = 3'd5;
    localparam logic [2:0] REQ_RSVD6 = 3'd6;
    localparam logic [2:0] REQ_RSVD7 = 3'd7;

    localparam logic signed [31:0] KEY_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] KEY_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] nb;
        logic [4:0]         occ;
    } t_answer;

    typedef struct {
        logic [2:0]         kind;
        logic signed [31:0] key;
        int                 rep;
        bit                 typed;
        t_answer            ans;
    } t_row;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    logic [2:0]         i_req_type  = '0;
    logic signed [31:0] i_key       = '0;
    logic               i_out_ready = 1'b0;
    logic               o_in_ready;
    logic               o_out_valid;
    logic [1:0]         o_status;
    logic signed [31:0] o_neighbour;
    logic [4:0]         o_occupancy;

    // Shadow copy of the set, kept in ascending signed order.
    logic signed [31:0] shadow_keys [SET_CAP];
    int                 shadow_count = 0;

    t_answer  answers_due [$];
    t_row     plan [$];
    int       cycles      = 0;
    int       mismatches  = 0;
    int       items_sent  = 0;
    int       results_ok  = 0;
    int       status_seen [4] = '{0, 0, 0, 0};
    bit       no_idle     = 1'b0;
    bit       hold_req    = 1'b0;
    int       holds_done  = 0;

    sorted_set_engine_core #(
        .CAPACITY(SET_CAP)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_req_type  (i_req_type),
        .i_key       (i_key),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_status    (o_status),
        .o_neighbour (o_neighbour),
        .o_occupancy (o_occupancy)
    );

    always #6 i_clk = ~i_clk;

    // Applies one request to the shadow set and returns the result it causes.
    function automatic t_answer apply_request(input logic [2:0] kind,
                                              input logic signed [31:0] key);
        t_answer ans;
        int      pos;
        int      j;
        bit      hit;
        pos = 0;
        while (pos < shadow_count && shadow_keys[pos] < key)
            pos++;
        hit = (pos < shadow_count) && (shadow_keys[pos] == key);
        ans.status = sse_pkg::ST_ABSENT;
        ans.nb = '0;
        case (kind)
            sse_pkg::REQ_INSERT: begin
                if (hit) begin
                    ans.status = sse_pkg::ST_DUP;
                end else if (shadow_count >= SET_CAP) begin
                    ans.status = sse_pkg::ST_FULL;
                end else begin
                    for (j = shadow_count; j > pos; j--)
                        shadow_keys[j] = shadow_keys[j-1];
                    shadow_keys[pos] = key;
                    shadow_count++;
                    ans.status = sse_pkg::ST_DONE;
                end
            end
            sse_pkg::REQ_REMOVE: begin
                if (hit) begin
                    for (j = pos; j + 1 < shadow_count; j++)
                        shadow_keys[j] = shadow_keys[j+1];
                    shadow_count--;
                    ans.status = sse_pkg::ST_DONE;
                end
            end
            sse_pkg::REQ_SEARCH: begin
                if (hit)
                    ans.status = sse_pkg::ST_DONE;
            end
            sse_pkg::REQ_PRED: begin
                if (pos > 0) begin
                    ans.nb = shadow_keys[pos-1];
                    ans.status = sse_pkg::ST_DONE;
                end
            end
            sse_pkg::REQ_SUCC: begin
                // The successor skips over the key itself when it is stored.
                j = hit ? pos + 1 : pos;
                if (j < shadow_count) begin
                    ans.nb = shadow_keys[j];
                    ans.status = sse_pkg::ST_DONE;
                end
            end
            default: begin
            end
        endcase
        ans.occ = 5'(shadow_count);
        return ans;
    endfunction

    function automatic t_answer answer_of(input logic [1:0] st, input logic signed [31:0] nb,
                                          input int occ);
        t_answer a;
        a.status = st;
        a.nb = nb;
        a.occ = 5'(occ);
        return a;
    endfunction

    task automatic add_row(input logic [2:0] kind, input logic signed [31:0] key, input int rep,
                           input bit typed, input t_answer ans);
        t_row r;
        r.kind = kind;
        r.key = key;
        r.rep = rep;
        r.typed = typed;
        r.ans = ans;
        plan.push_back(r);
    endtask

    function automatic logic signed [31:0] pick_key();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return int'($urandom_range(0, 23)) - 12;
        if (r < 70) begin
            case ($urandom_range(0, 5))
                0:       return KEY_MIN;
                1:       return KEY_MIN + 1;
                2:       return KEY_MAX;
                3:       return KEY_MAX - 1;
                4:       return 0;
                default: return -1;
            endcase
        end
        return $urandom;
    endfunction

    // Fill phases lean on inserts so the set reaches capacity; drain phases empty it.
    function automatic logic [2:0] pick_kind(input bit filling);
        int r;
        int w_ins;
        int w_rem;
        r = $urandom_range(0, 99);
        w_ins = filling ? 50 : 15;
        w_rem = filling ? 10 : 45;
        if (r < w_ins)                return sse_pkg::REQ_INSERT;
        if (r < w_ins + w_rem)        return sse_pkg::REQ_REMOVE;
        if (r < w_ins + w_rem + 13)   return sse_pkg::REQ_SEARCH;
        if (r < w_ins + w_rem + 25)   return sse_pkg::REQ_PRED;
        if (r < w_ins + w_rem + 37)   return sse_pkg::REQ_SUCC;
        case ($urandom_range(0, 2))
            0:       return REQ_RSVD5;
            1:       return REQ_RSVD6;
            default: return REQ_RSVD7;
        endcase
    endfunction

    // Offers one item, waits for it to be taken, then books its expected result.
    task automatic send_item(input logic [2:0] kind, input logic signed [31:0] key,
                             input bit typed, input t_answer typed_ans);
        t_answer ans;
        i_in_valid <= 1'b1;
        i_req_type <= kind;
        i_key <= key;
        do
            @(posedge i_clk);
        while (!o_in_ready);
        ans = apply_request(kind, key);
        if (typed)
            ans = typed_ans;
        answers_due.push_back(ans);
        items_sent++;
        while (!no_idle && $urandom_range(0, 99) < 12) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    // Receiver side: random back-pressure, plus one long hold-off on request.
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                for (int c = 0; c < HOLD_LEN; c++) begin
                    i_out_ready <= 1'b0;
                    @(posedge i_clk);
                end
                hold_req = 1'b0;
                holds_done++;
            end else begin
                i_out_ready <= no_idle || ($urandom_range(0, 99) >= 12);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (answers_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: status %0d neighbour %0d occupancy %0d",
                             o_status, o_neighbour, o_occupancy);
            end else begin
                t_answer want;
                want = answers_due.pop_front();
                status_seen[o_status]++;
                if (o_status !== want.status || o_neighbour !== want.nb
                        || o_occupancy !== want.occ) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result %0d exp/act: status %0d/%0d nb %0d/%0d occ %0d/%0d",
                                 results_ok + mismatches, want.status, o_status,
                                 want.nb, o_neighbour, want.occ, o_occupancy);
                end else begin
                    results_ok++;
                end
            end
        end
    end

    initial begin
        while (cycles < RUN_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("timeout after %0d cycles, %0d results outstanding", cycles, answers_due.size());
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        t_row row;
        bit   filling;

        // Empty set, then the two extreme keys and every kind against them.
        add_row(sse_pkg::REQ_SEARCH, 0,       1, 1, answer_of(sse_pkg::ST_ABSENT, 0, 0));
        add_row(sse_pkg::REQ_PRED,   0,       1, 1, answer_of(sse_pkg::ST_ABSENT, 0, 0));
        add_row(sse_pkg::REQ_SUCC,   0,       1, 1, answer_of(sse_pkg::ST_ABSENT, 0, 0));
        add_row(sse_pkg::REQ_REMOVE, 0,       1, 1, answer_of(sse_pkg::ST_ABSENT, 0, 0));
        add_row(sse_pkg::REQ_INSERT, KEY_MAX, 1, 1, answer_of(sse_pkg::ST_DONE, 0, 1));
        add_row(sse_pkg::REQ_INSERT, KEY_MIN, 1, 1, answer_of(sse_pkg::ST_DONE, 0, 2));
        add_row(sse_pkg::REQ_INSERT, KEY_MAX, 1, 1, answer_of(sse_pkg::ST_DUP, 0, 2));
        add_row(sse_pkg::REQ_SEARCH, KEY_MIN, 1, 1, answer_of(sse_pkg::ST_DONE, 0, 2));
        add_row(sse_pkg::REQ_PRED,   KEY_MIN, 1, 1, answer_of(sse_pkg::ST_ABSENT, 0, 2));
        add_row(sse_pkg::REQ_SUCC,   KEY_MAX, 1, 1, answer_of(sse_pkg::ST_ABSENT, 0, 2));
        add_row(sse_pkg::REQ_PRED,   KEY_MAX, 1, 1, answer_of(sse_pkg::ST_DONE, KEY_MIN, 2));
        add_row(sse_pkg::REQ_SUCC,   KEY_MIN, 1, 1, answer_of(sse_pkg::ST_DONE, KEY_MAX, 2));
        add_row(REQ_RSVD5,           -1,      1, 1, answer_of(sse_pkg::ST_ABSENT, 0, 2));
        add_row(REQ_RSVD6,           0,       1, 1, answer_of(sse_pkg::ST_ABSENT, 0, 2));
        add_row(REQ_RSVD7,           KEY_MAX, 1, 1, answer_of(sse_pkg::ST_ABSENT, 0, 2));
        add_row(sse_pkg::REQ_REMOVE, KEY_MIN, 1, 1, answer_of(sse_pkg::ST_DONE, 0, 1));
        // Fill to capacity with keys -5 to 9, then a refused insert and a
        // duplicate, which wins over the full condition.
        add_row(sse_pkg::REQ_INSERT, -5,      15, 0, '0);
        add_row(sse_pkg::REQ_INSERT, 1000,    1, 1, answer_of(sse_pkg::ST_FULL, 0, 16));
        add_row(sse_pkg::REQ_INSERT, -5,      1, 1, answer_of(sse_pkg::ST_DUP, 0, 16));
        add_row(sse_pkg::REQ_PRED,   0,       1, 0, '0);
        add_row(sse_pkg::REQ_SUCC,   -3,      1, 0, '0);
        add_row(sse_pkg::REQ_PRED,   -7,      1, 0, '0);
        add_row(sse_pkg::REQ_SUCC,   100,     1, 0, '0);
        add_row(sse_pkg::REQ_REMOVE, 9,       1, 0, '0);
        add_row(sse_pkg::REQ_SEARCH, 9,       1, 0, '0);

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[n]) begin
            row = plan[n];
            for (int k = 0; k < row.rep; k++)
                send_item(row.kind, row.key + k, row.typed, row.ans);
        end

        filling = 1'b1;
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n % 100 == 0)
                filling = !filling || (n == 0);
            if (n == 300)
                hold_req = 1'b1;
            if (n == 700)
                no_idle = 1'b1;
            if (n == 900)
                no_idle = 1'b0;
            if (n == 600) begin
                i_in_valid <= 1'b0;
                while (answers_due.size() != 0)
                    @(posedge i_clk);
            end
            send_item(pick_kind(filling), pick_key(), 1'b0, '0);
        end
        i_in_valid <= 1'b0;

        while (answers_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);

        $display("covered %0d items in %0d cycles, %0d long receiver hold-offs",
                 items_sent, cycles, holds_done);
        $display("results by status: done %0d, absent %0d, duplicate %0d, refused %0d",
                 status_seen[sse_pkg::ST_DONE], status_seen[sse_pkg::ST_ABSENT],
                 status_seen[sse_pkg::ST_DUP], status_seen[sse_pkg::ST_FULL]);
        if (mismatches == 0 && answers_due.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatches, answers_due.size());
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
